// ===== src/scsa_pkg.sv =====
package scsa_pkg;

    localparam int NUM_PAGES   = 64;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int LINK_W      = PAGE_W + 1;
    localparam int OBJ_W       = 8;
    localparam int OBJ_AW      = PAGE_W + OBJ_W;
    localparam int PAGE_BYTES  = 4096;
    localparam int SLAB_HEADER_BYTES = 16;
    localparam int OBJ_HEADER_BYTES  = 8;
    localparam int OBJ_OFFSET  = (SLAB_HEADER_BYTES + 3) & ~3;
    localparam int NUM_LISTS   = 24;
    localparam int INFO_W      = 28;

    localparam logic [LINK_W-1:0] NIL_PAGE   = LINK_W'(NUM_PAGES);
    localparam logic [3:0]        KIND_LARGE = 4'd8;
    localparam logic [7:0]        NO_OBJ     = 8'hFF;

    localparam logic [1:0] LIST_PARTIAL = 2'd0;
    localparam logic [1:0] LIST_FULL    = 2'd1;
    localparam logic [1:0] LIST_EMPTY   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOPAGE  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_POOL_BASE  = 1'b0;
    localparam logic CFG_POOL_PAGES = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic              cmd;
        logic              bad;
        logic [3:0]        cls;
        logic [PAGE_W-1:0] page;
        logic [11:0]       off;
    } req_t;

    // objects per slab of class c
    function automatic logic [7:0] cap_of(input logic [3:0] c);
        logic [11:0] span;
        span = 12'(PAGE_BYTES - OBJ_OFFSET);
        return 8'(span >> ({1'b0, c[2:0]} + 4'd4));
    endfunction

endpackage

// ===== src/scsa_ram.sv =====
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/scsa_front.sv =====
module scsa_front
    import scsa_pkg::*;
(
    input  logic        cmd,
    input  logic [31:0] req_size,
    input  logic [31:0] free_addr,
    input  logic [31:0] base_al,
    output req_t        req
);

    logic [32:0] need;
    logic [31:0] off;

    // smallest class that holds size plus header; loop runs down so smallest wins
    always_comb
    begin
        need = {1'b0, req_size} + 33'(OBJ_HEADER_BYTES);
        off  = free_addr - 32'(OBJ_HEADER_BYTES) - base_al;
        req.cmd  = cmd;
        req.cls  = KIND_LARGE;
        for (int c = 7; c >= 0; c--)
        begin
            if (need <= (33'd16 << c))
            begin
                req.cls = 4'(c);
            end
        end
        req.bad  = (free_addr < 32'(OBJ_HEADER_BYTES)) || (off[31:12+PAGE_W] != '0);
        req.page = off[12+PAGE_W-1:12];
        req.off  = off[11:0];
    end

endmodule

// ===== src/scsa_fifo.sv =====
module scsa_fifo
    import scsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output req_t pop_data
);

    req_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/scsa_back.sv =====
module scsa_back
    import scsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] base_al,
    input  logic [6:0]  pool_pages,
    input  logic        q_valid,
    input  req_t        q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_addr,
    output logic [1:0]  status,
    output logic [3:0]  size_class
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_AHEAD  = 14'b00000000000010,
        S_AUNE   = 14'b00000000000100,
        S_AINFO  = 14'b00000000001000,
        S_APICK  = 14'b00000000010000,
        S_APOP   = 14'b00000000100000,
        S_AUPD   = 14'b00000001000000,
        S_AFULL  = 14'b00000010000000,
        S_AFULL2 = 14'b00000100000000,
        S_FINFO  = 14'b00001000000000,
        S_FLIVE  = 14'b00010000000000,
        S_FUNL   = 14'b00100000000000,
        S_FPUSH  = 14'b01000000000000,
        S_FPUSH2 = 14'b10000000000000
    } state_t;

    function automatic logic [4:0] hidx(input logic [3:0] c, input logic [1:0] l);
        return {1'b0, c[2:0], 1'b0} + {2'b0, c[2:0]} + {3'b0, l};
    endfunction

    state_t             state_reg, state_next;
    logic [3:0]         cls_reg, cls_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [11:0]        off_reg, off_next;
    logic [7:0]         obj_reg, obj_next;
    logic [7:0]         use_reg, use_next;
    logic [7:0]         fh_reg, fh_next;
    logic [7:0]         fresh_reg, fresh_next;
    logic               full_reg, full_next;
    logic [LINK_W-1:0]  hsave_reg, hsave_next;
    logic [6:0]         used_reg, used_next;
    logic [LINK_W-1:0]  heads_reg [NUM_LISTS];
    logic [LINK_W-1:0]  heads_next [NUM_LISTS];
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        addr_reg, addr_next;
    logic [1:0]         st_reg, st_next;
    logic [3:0]         ocls_reg, ocls_next;

    // page and object memories
    logic               info_we;
    logic [PAGE_W-1:0]  info_waddr, info_raddr;
    logic [INFO_W-1:0]  info_wdata, info_rdata;
    logic               pn_we;
    logic [PAGE_W-1:0]  pn_waddr, pn_raddr;
    logic [LINK_W-1:0]  pn_wdata, pn_rdata;
    logic               pp_we;
    logic [PAGE_W-1:0]  pp_waddr, pp_raddr;
    logic [LINK_W-1:0]  pp_wdata, pp_rdata;
    logic               on_we;
    logic [OBJ_AW-1:0]  on_waddr, on_raddr;
    logic [7:0]         on_wdata, on_rdata;
    logic               lv_we;
    logic [OBJ_AW-1:0]  lv_waddr, lv_raddr;
    logic               lv_wdata, lv_rdata;

    scsa_ram #(.WIDTH(INFO_W), .DEPTH(NUM_PAGES)) u_info (
        .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata));
    scsa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_pnext (
        .clk(clk), .we(pn_we), .waddr(pn_waddr), .wdata(pn_wdata),
        .raddr(pn_raddr), .rdata(pn_rdata));
    scsa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_pprev (
        .clk(clk), .we(pp_we), .waddr(pp_waddr), .wdata(pp_wdata),
        .raddr(pp_raddr), .rdata(pp_rdata));
    scsa_ram #(.WIDTH(8), .DEPTH(NUM_PAGES * 256)) u_onext (
        .clk(clk), .we(on_we), .waddr(on_waddr), .wdata(on_wdata),
        .raddr(on_raddr), .rdata(on_rdata));
    scsa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES * 256)) u_live (
        .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
        .raddr(lv_raddr), .rdata(lv_rdata));

    assign out_valid   = out_valid_reg;
    assign result_addr = addr_reg;
    assign status      = st_reg;
    assign size_class  = ocls_reg;

    logic [6:0]        limit;
    logic              avail;
    logic [7:0]        cap;
    logic [31:0]       page_base;
    logic [31:0]       slab_addr;
    logic [LINK_W-1:0] hp, he, hx;
    logic [3:0]        kind;
    logic [3:0]        sh;
    logic [11:0]       dsp;
    logic [7:0]        fi;
    logic              f_ok;
    logic [7:0]        use_n;
    logic [1:0]        lsel;

    always_comb
    begin
        limit      = (pool_pages < 7'(NUM_PAGES)) ? pool_pages : 7'(NUM_PAGES);
        avail      = used_reg < limit;
        cap        = cap_of(cls_reg);
        page_base  = base_al + {(20 - PAGE_W)'(0), page_reg, 12'h000};
        slab_addr  = page_base + 32'(OBJ_OFFSET + OBJ_HEADER_BYTES)
                   + (32'(obj_reg) << ({1'b0, cls_reg[2:0]} + 4'd4));
        hp = heads_reg[hidx(cls_reg, LIST_PARTIAL)];
        he = heads_reg[hidx(cls_reg, LIST_EMPTY)];
        hx = NIL_PAGE;
        kind  = info_rdata[27:24];
        sh    = {1'b0, kind[2:0]} + 4'd4;
        dsp   = off_reg - 12'(OBJ_OFFSET);
        fi    = 8'(dsp >> sh);
        f_ok  = 1'b0;
        use_n = 8'd0;
        lsel  = LIST_PARTIAL;

        state_next  = state_reg;
        cls_next    = cls_reg;
        page_next   = page_reg;
        off_next    = off_reg;
        obj_next    = obj_reg;
        use_next    = use_reg;
        fh_next     = fh_reg;
        fresh_next  = fresh_reg;
        full_next   = full_reg;
        hsave_next  = hsave_reg;
        used_next   = used_reg;
        heads_next  = heads_reg;
        addr_next   = addr_reg;
        st_next     = st_reg;
        ocls_next   = ocls_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop = 1'b0;

        info_we = 1'b0; info_waddr = page_reg; info_raddr = page_reg;
        info_wdata = {cls_reg, use_reg, fh_reg, fresh_reg};
        pn_we = 1'b0; pn_waddr = page_reg; pn_raddr = page_reg; pn_wdata = NIL_PAGE;
        pp_we = 1'b0; pp_waddr = page_reg; pp_raddr = page_reg; pp_wdata = NIL_PAGE;
        on_we = 1'b0; on_waddr = {page_reg, obj_reg}; on_raddr = {page_reg, fh_reg};
        on_wdata = fh_reg;
        lv_we = 1'b0; lv_waddr = {page_reg, obj_reg}; lv_raddr = {page_reg, obj_reg};
        lv_wdata = 1'b0;

        unique case (state_reg)
            // dispatch a request once the result register is free or being taken
            S_IDLE:
            begin
                if (q_valid && (!out_valid_reg || out_ready))
                begin
                    q_pop     = 1'b1;
                    cls_next  = q_data.cls;
                    page_next = q_data.page;
                    off_next  = q_data.off;
                    if (q_data.cmd == CMD_ALLOC)
                    begin
                        if (q_data.cls == KIND_LARGE)
                        begin
                            out_valid_next = 1'b1;
                            ocls_next      = KIND_LARGE;
                            if (avail)
                            begin
                                page_next  = used_reg[PAGE_W-1:0];
                                used_next  = used_reg + 7'd1;
                                info_we    = 1'b1;
                                info_waddr = used_reg[PAGE_W-1:0];
                                info_wdata = {KIND_LARGE, 8'd0, NO_OBJ, 8'd0};
                                lv_we      = 1'b1;
                                lv_waddr   = {used_reg[PAGE_W-1:0], 8'd0};
                                lv_wdata   = 1'b1;
                                addr_next  = base_al
                                           + {(20 - PAGE_W)'(0), used_reg[PAGE_W-1:0], 12'h000}
                                           + 32'(OBJ_HEADER_BYTES);
                                st_next    = ST_DONE;
                            end
                            else
                            begin
                                addr_next = 32'd0;
                                st_next   = ST_NOPAGE;
                            end
                        end
                        else
                        begin
                            state_next = S_AHEAD;
                        end
                    end
                    else if (q_data.bad || ({1'b0, q_data.page} >= used_reg))
                    begin
                        out_valid_next = 1'b1;
                        addr_next      = 32'd0;
                        st_next        = ST_IGNORED;
                        ocls_next      = 4'd0;
                    end
                    else
                    begin
                        info_raddr = q_data.page;
                        state_next = S_FINFO;
                    end
                end
            end

            // pick a slab: partial head, empty head, or a fresh page; else report no page
            S_AHEAD:
            begin
                if (hp != NIL_PAGE)
                begin
                    page_next  = hp[PAGE_W-1:0];
                    info_raddr = hp[PAGE_W-1:0];
                    state_next = S_AINFO;
                end
                else if (he != NIL_PAGE)
                begin
                    page_next  = he[PAGE_W-1:0];
                    pn_raddr   = he[PAGE_W-1:0];
                    state_next = S_AUNE;
                end
                else if (avail)
                begin
                    page_next  = used_reg[PAGE_W-1:0];
                    used_next  = used_reg + 7'd1;
                    use_next   = 8'd0;
                    fh_next    = NO_OBJ;
                    fresh_next = 8'd0;
                    pn_we      = 1'b1;
                    pn_waddr   = used_reg[PAGE_W-1:0];
                    pp_we      = 1'b1;
                    pp_waddr   = used_reg[PAGE_W-1:0];
                    heads_next[hidx(cls_reg, LIST_PARTIAL)] = used_reg[LINK_W-1:0];
                    state_next = S_APICK;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    addr_next      = 32'd0;
                    st_next        = ST_NOPAGE;
                    ocls_next      = cls_reg;
                    state_next     = S_IDLE;
                end
            end

            // move empty head onto the partial list
            S_AUNE:
            begin
                heads_next[hidx(cls_reg, LIST_EMPTY)]   = pn_rdata;
                heads_next[hidx(cls_reg, LIST_PARTIAL)] = {1'b0, page_reg};
                if (pn_rdata != NIL_PAGE)
                begin
                    pp_we    = 1'b1;
                    pp_waddr = pn_rdata[PAGE_W-1:0];
                end
                pn_we      = 1'b1;
                state_next = S_AINFO;
            end

            S_AINFO:
            begin
                use_next   = info_rdata[23:16];
                fh_next    = info_rdata[15:8];
                fresh_next = info_rdata[7:0];
                state_next = S_APICK;
            end

            // free list first, else next never-used object
            S_APICK:
            begin
                if ((fh_reg != NO_OBJ) && (fh_reg < cap))
                begin
                    obj_next   = fh_reg;
                    on_raddr   = {page_reg, fh_reg};
                    state_next = S_APOP;
                end
                else
                begin
                    obj_next   = (fresh_reg >= cap) ? (cap - 8'd1) : fresh_reg;
                    fresh_next = ((fresh_reg >= cap) ? (cap - 8'd1) : fresh_reg) + 8'd1;
                    state_next = S_AUPD;
                end
            end

            S_APOP:
            begin
                fh_next    = on_rdata;
                state_next = S_AUPD;
            end

            S_AUPD:
            begin
                use_n      = use_reg + 8'd1;
                use_next   = use_n;
                info_we    = 1'b1;
                info_wdata = {cls_reg, use_n, fh_reg, fresh_reg};
                lv_we      = 1'b1;
                lv_wdata   = 1'b1;
                if (use_n >= cap)
                begin
                    pn_raddr   = page_reg;
                    state_next = S_AFULL;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    addr_next      = slab_addr;
                    st_next        = ST_DONE;
                    ocls_next      = cls_reg;
                    state_next     = S_IDLE;
                end
            end

            // slab is full: pop it off partial, push onto full
            S_AFULL:
            begin
                heads_next[hidx(cls_reg, LIST_PARTIAL)] = pn_rdata;
                if (pn_rdata != NIL_PAGE)
                begin
                    pp_we    = 1'b1;
                    pp_waddr = pn_rdata[PAGE_W-1:0];
                end
                hx         = heads_reg[hidx(cls_reg, LIST_FULL)];
                pn_we      = 1'b1;
                pn_wdata   = hx;
                hsave_next = hx;
                heads_next[hidx(cls_reg, LIST_FULL)] = {1'b0, page_reg};
                state_next = S_AFULL2;
            end

            S_AFULL2:
            begin
                if (hsave_reg != NIL_PAGE)
                begin
                    pp_we    = 1'b1;
                    pp_waddr = hsave_reg[PAGE_W-1:0];
                    pp_wdata = {1'b0, page_reg};
                end
                out_valid_next = 1'b1;
                addr_next      = slab_addr;
                st_next        = ST_DONE;
                ocls_next      = cls_reg;
                state_next     = S_IDLE;
            end

            // decode the object inside the page; ignore a bad offset
            S_FINFO:
            begin
                cls_next   = kind;
                use_next   = info_rdata[23:16];
                fh_next    = info_rdata[15:8];
                fresh_next = info_rdata[7:0];
                if (kind == KIND_LARGE)
                begin
                    f_ok     = (off_reg == 12'd0);
                    obj_next = 8'd0;
                    lv_raddr = {page_reg, 8'd0};
                end
                else
                begin
                    f_ok = (kind[3] == 1'b0) && (off_reg >= 12'(OBJ_OFFSET))
                         && ((dsp & ((12'd1 << sh) - 12'd1)) == 12'd0)
                         && (fi < cap_of(kind));
                    obj_next = fi;
                    lv_raddr = {page_reg, fi};
                end
                if (f_ok)
                begin
                    state_next = S_FLIVE;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    addr_next      = 32'd0;
                    st_next        = ST_IGNORED;
                    ocls_next      = 4'd0;
                    state_next     = S_IDLE;
                end
            end

            // objects at or past the fresh index were never handed out
            S_FLIVE:
            begin
                if (!lv_rdata || ((cls_reg != KIND_LARGE) && (obj_reg >= fresh_reg)))
                begin
                    out_valid_next = 1'b1;
                    addr_next      = 32'd0;
                    st_next        = ST_IGNORED;
                    ocls_next      = 4'd0;
                    state_next     = S_IDLE;
                end
                else if (cls_reg == KIND_LARGE)
                begin
                    lv_we          = 1'b1;
                    out_valid_next = 1'b1;
                    addr_next      = 32'd0;
                    st_next        = ST_DONE;
                    ocls_next      = KIND_LARGE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    use_n      = (use_reg != 8'd0) ? (use_reg - 8'd1) : 8'd0;
                    lv_we      = 1'b1;
                    on_we      = 1'b1;
                    fh_next    = obj_reg;
                    use_next   = use_n;
                    info_we    = 1'b1;
                    info_wdata = {cls_reg, use_n, obj_reg, fresh_reg};
                    full_next  = (use_reg >= cap);
                    if ((use_reg >= cap) || (use_n == 8'd0))
                    begin
                        state_next = S_FUNL;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        addr_next      = 32'd0;
                        st_next        = ST_DONE;
                        ocls_next      = cls_reg;
                        state_next     = S_IDLE;
                    end
                end
            end

            // unlink from the old list
            S_FUNL:
            begin
                lsel = full_reg ? LIST_FULL : LIST_PARTIAL;
                if (pp_rdata != NIL_PAGE)
                begin
                    pn_we    = 1'b1;
                    pn_waddr = pp_rdata[PAGE_W-1:0];
                    pn_wdata = pn_rdata;
                end
                else
                begin
                    heads_next[hidx(cls_reg, lsel)] = pn_rdata;
                end
                if (pn_rdata != NIL_PAGE)
                begin
                    pp_we    = 1'b1;
                    pp_waddr = pn_rdata[PAGE_W-1:0];
                    pp_wdata = pp_rdata;
                end
                state_next = S_FPUSH;
            end

            // push at the head of the new list
            S_FPUSH:
            begin
                lsel       = (use_reg == 8'd0) ? LIST_EMPTY : LIST_PARTIAL;
                hx         = heads_reg[hidx(cls_reg, lsel)];
                pn_we      = 1'b1;
                pn_wdata   = hx;
                pp_we      = 1'b1;
                hsave_next = hx;
                heads_next[hidx(cls_reg, lsel)] = {1'b0, page_reg};
                state_next = S_FPUSH2;
            end

            S_FPUSH2:
            begin
                if (hsave_reg != NIL_PAGE)
                begin
                    pp_we    = 1'b1;
                    pp_waddr = hsave_reg[PAGE_W-1:0];
                    pp_wdata = {1'b0, page_reg};
                end
                out_valid_next = 1'b1;
                addr_next      = 32'd0;
                st_next        = ST_DONE;
                ocls_next      = cls_reg;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_FLIVE)
        begin
            pn_raddr = page_reg;
            pp_raddr = page_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cls_reg   <= cls_next;
        page_reg  <= page_next;
        off_reg   <= off_next;
        obj_reg   <= obj_next;
        use_reg   <= use_next;
        fh_reg    <= fh_next;
        fresh_reg <= fresh_next;
        full_reg  <= full_next;
        hsave_reg <= hsave_next;
        addr_reg  <= addr_next;
        st_reg    <= st_next;
        ocls_reg  <= ocls_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                heads_reg[k] <= NIL_PAGE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            heads_reg     <= heads_next;
        end
    end

endmodule

// ===== src/size_class_slab_allocator.sv =====
// Slab allocator with eight power-of-two size classes (16..2048 bytes)
// and whole-page large objects, over a pool of pages from a bump pointer.
//
// Input stream (s_*): one beat is an allocate or free request. Output stream
// (m_*): exactly one result beat per request, in request order. Config port:
// cfg_we/cfg_index/cfg_data write pool_base (index 0) or pool_pages (index 1);
// the user must write only while no request is in flight; it is unchecked.
//
// A front stage classifies each beat into a two-entry queue; a back-end
// sequencer does the list and free-list updates through registered-read
// memories and holds each request through a chain of dependent reads: a
// large alloc, or a free of a bad address or unused page, ends in the
// dispatch cycle; an alloc picks a slab, loads its state, picks an object,
// updates and moves a filled slab to the full list; a free reads info,
// checks the live bit and relinks the slab if it changes list. The next
// request is dispatched once the result register is free or being taken.
// Reset clears the page counter, all slab lists and the queue; no memory
// clearing pass is needed. When m_tready is low the result is held, the
// sequencer waits, and the queue keeps taking up to two more requests.
module size_class_slab_allocator
    import scsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // req_size, free_addr
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_addr, status, size_class, zero pad
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] pool_base_reg;
    logic [6:0]  pool_pages_reg;
    logic [31:0] base_al;
    req_t        fr_req;
    req_t        q_data;
    logic        q_full, q_valid, q_pop;
    logic [31:0] result_addr;
    logic [1:0]  status;
    logic [3:0]  size_class;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= 32'd1048576;
            pool_pages_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_BASE:  pool_base_reg  <= cfg_data;
                CFG_POOL_PAGES: pool_pages_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign base_al  = {pool_base_reg[31:12], 12'h000};
    assign s_tready = !q_full;
    assign m_tdata  = {2'b00, size_class, status, result_addr};

    scsa_front u_front (
        .cmd(s_tuser),
        .req_size(s_tdata[31:0]),
        .free_addr(s_tdata[63:32]),
        .base_al(base_al),
        .req(fr_req)
    );

    scsa_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(s_tvalid && !q_full),
        .push_data(fr_req),
        .full(q_full),
        .pop(q_pop),
        .valid(q_valid),
        .pop_data(q_data)
    );

    scsa_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .base_al(base_al),
        .pool_pages(pool_pages_reg),
        .q_valid(q_valid),
        .q_data(q_data),
        .q_pop(q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .result_addr(result_addr),
        .status(status),
        .size_class(size_class)
    );

endmodule

// ===== tb/tb_size_class_slab_allocator.sv =====
`timescale 1ns / 1ps

module tb_size_class_slab_allocator;
    import scsa_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  st;
        logic [3:0]  cls;
    } alloc_result_t;

    localparam int NIL        = NUM_PAGES;
    localparam int LIMIT_CYC  = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    size_class_slab_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow allocator state
    logic [31:0] sh_base;
    logic [6:0]  sh_pages;
    int          sh_used;
    logic [3:0]  sh_kind [NUM_PAGES];
    logic [7:0]  sh_count [NUM_PAGES];
    logic [7:0]  sh_fhead [NUM_PAGES];
    logic [7:0]  sh_fresh [NUM_PAGES];
    int          sh_next_pg [NUM_PAGES];
    int          sh_prev_pg [NUM_PAGES];
    int          sh_heads [NUM_LISTS];
    logic [7:0]  sh_obj_next [NUM_PAGES*255];
    bit          sh_obj_live [NUM_PAGES*256];

    // pending beats: free_addr, req_size, cmd
    logic [64:0]   req_q [$];
    alloc_result_t result_q [$];
    logic [31:0]   live_offs [$];
    logic [31:0]   freed_offs [$];

    int  n_pushed;
    int  n_taken;
    int  errors;
    int  cycles;
    int  send_idle;
    int  recv_idle;
    int  hold_cnt;
    bit  beat_taken;

    function automatic int slab_cap(input int c);
        return (PAGE_BYTES - OBJ_OFFSET) >> (4 + c);
    endfunction

    function automatic logic [31:0] base_al();
        return sh_base & 32'hFFFFF000;
    endfunction

    function automatic void list_unlink(input int l, input int p);
        int nx;
        int pv;
        nx = sh_next_pg[p];
        pv = sh_prev_pg[p];
        if (pv != NIL) sh_next_pg[pv] = nx;
        else sh_heads[l] = nx;
        if (nx != NIL) sh_prev_pg[nx] = pv;
        sh_next_pg[p] = NIL;
        sh_prev_pg[p] = NIL;
    endfunction

    function automatic void page_push(input int l, input int p);
        int h;
        h = sh_heads[l];
        sh_prev_pg[p] = NIL;
        sh_next_pg[p] = h;
        if (h != NIL) sh_prev_pg[h] = p;
        sh_heads[l] = p;
    endfunction

    function automatic bit grab_page(output int p);
        int lim;
        lim = (sh_pages < NUM_PAGES) ? sh_pages : NUM_PAGES;
        p = sh_used;
        if (sh_used >= lim) return 0;
        sh_used++;
        return 1;
    endfunction

    function automatic alloc_result_t predict_alloc(input logic [31:0] size);
        alloc_result_t r;
        logic [63:0]   need;
        int c;
        int p;
        int cap;
        int i;
        need = 64'(size) + OBJ_HEADER_BYTES;
        c = 0;
        while (c < 8 && need > (64'd16 << c)) c++;
        r = '0;
        if (c == 8) begin
            r.cls = KIND_LARGE;
            if (!grab_page(p)) begin
                r.st = ST_NOPAGE;
                return r;
            end
            sh_kind[p] = KIND_LARGE;
            sh_obj_live[p*256] = 1;
            r.addr = base_al() + p * PAGE_BYTES + OBJ_HEADER_BYTES;
            r.st = ST_DONE;
            return r;
        end
        r.cls = 4'(c);
        cap = slab_cap(c);
        p = sh_heads[c*3 + LIST_PARTIAL];
        if (p == NIL) begin
            p = sh_heads[c*3 + LIST_EMPTY];
            if (p != NIL) list_unlink(c*3 + LIST_EMPTY, p);
            else begin
                if (!grab_page(p)) begin
                    r.st = ST_NOPAGE;
                    return r;
                end
                sh_kind[p] = 4'(c);
                sh_count[p] = 0;
                sh_fhead[p] = NO_OBJ;
                sh_fresh[p] = 0;
                sh_next_pg[p] = NIL;
                sh_prev_pg[p] = NIL;
            end
            page_push(c*3 + LIST_PARTIAL, p);
        end
        if (sh_fhead[p] != NO_OBJ && sh_fhead[p] < cap) begin
            i = sh_fhead[p];
            sh_fhead[p] = sh_obj_next[p*255 + i];
        end
        else begin
            i = sh_fresh[p];
            if (i >= cap) i = cap - 1;
            sh_fresh[p] = 8'(i + 1);
        end
        sh_count[p]++;
        sh_obj_live[p*256 + i] = 1;
        if (sh_count[p] >= cap) begin
            list_unlink(c*3 + LIST_PARTIAL, p);
            page_push(c*3 + LIST_FULL, p);
        end
        r.addr = base_al() + p * PAGE_BYTES + OBJ_OFFSET + (i << (4 + c)) + OBJ_HEADER_BYTES;
        r.st = ST_DONE;
        return r;
    endfunction

    function automatic alloc_result_t predict_free(input logic [31:0] addr);
        alloc_result_t r;
        logic [31:0] off;
        int p;
        int inpg;
        int k;
        int d;
        int sh;
        int i;
        int cap;
        bit had_full;
        r = '0;
        r.st = ST_IGNORED;
        if (addr < OBJ_HEADER_BYTES) return r;
        off = (addr - OBJ_HEADER_BYTES) - base_al();
        p = int'(off >> 12);
        inpg = int'(off & 32'hFFF);
        if (p >= sh_used || p >= NUM_PAGES) return r;
        k = sh_kind[p];
        if (k == KIND_LARGE) begin
            if (inpg != 0 || !sh_obj_live[p*256]) return r;
            sh_obj_live[p*256] = 0;
            r.st = ST_DONE;
            r.cls = KIND_LARGE;
            return r;
        end
        if (k >= 8 || inpg < OBJ_OFFSET) return r;
        d = inpg - OBJ_OFFSET;
        sh = 4 + k;
        i = d >> sh;
        cap = slab_cap(k);
        if ((d & ((1 << sh) - 1)) != 0 || i >= cap || !sh_obj_live[p*256 + i]) return r;
        had_full = sh_count[p] >= cap;
        sh_obj_live[p*256 + i] = 0;
        sh_obj_next[p*255 + i] = sh_fhead[p];
        sh_fhead[p] = 8'(i);
        if (sh_count[p] > 0) sh_count[p]--;
        if (had_full || sh_count[p] == 0) begin
            list_unlink(k*3 + (had_full ? LIST_FULL : LIST_PARTIAL), p);
            page_push(k*3 + (sh_count[p] == 0 ? LIST_EMPTY : LIST_PARTIAL), p);
        end
        r.st = ST_DONE;
        r.cls = 4'(k);
        return r;
    endfunction

    // queue one request beat and its predicted result
    task automatic queue_req(input logic cmd, input logic [31:0] size, input logic [31:0] addr);
        alloc_result_t r;
        if (cmd == CMD_ALLOC) begin
            r = predict_alloc(size);
            if (r.st == ST_DONE) live_offs.push_back(r.addr - base_al());
        end
        else begin
            r = predict_free(addr);
        end
        result_q.push_back(r);
        req_q.push_back({addr, size, cmd});
        n_pushed++;
    endtask

    task automatic alloc_class(input int c);
        logic [31:0] lo;
        logic [31:0] hi;
        if (c >= 8) begin
            if ($urandom_range(3) == 0) queue_req(CMD_ALLOC, 32'hFFFFFFFF - $urandom_range(15), 0);
            else queue_req(CMD_ALLOC, $urandom_range(4096, 2041), 0);
        end
        else begin
            hi = (32'd16 << c) - 8;
            lo = (c == 0) ? 0 : (32'd8 << c) - 7;
            queue_req(CMD_ALLOC, $urandom_range(hi, lo), 0);
        end
    endtask

    task automatic free_live();
        int j;
        logic [31:0] o;
        j = $urandom_range(live_offs.size() - 1);
        o = live_offs[j];
        live_offs.delete(j);
        freed_offs.push_back(o);
        if (freed_offs.size() > 8) void'(freed_offs.pop_front());
        queue_req(CMD_FREE, $urandom, base_al() + o);
    endtask

    // malformed or stale frees
    task automatic free_noise();
        int sel;
        sel = $urandom_range(5);
        case (sel)
            0: queue_req(CMD_FREE, $urandom, 0);
            1: queue_req(CMD_FREE, $urandom, $urandom_range(7, 1));
            2: queue_req(CMD_FREE, $urandom, $urandom);
            3:
            begin
                if (live_offs.size() > 0)
                    queue_req(CMD_FREE, $urandom,
                              base_al() + live_offs[$urandom_range(live_offs.size()-1)]
                              + $urandom_range(15, 1));
                else queue_req(CMD_FREE, $urandom, base_al() + 8 + $urandom_range(4095));
            end
            default:
            begin
                if (freed_offs.size() > 0)
                    queue_req(CMD_FREE, $urandom,
                              base_al() + freed_offs[$urandom_range(freed_offs.size()-1)]);
                else queue_req(CMD_FREE, $urandom, base_al() + 4096*70);
            end
        endcase
    endtask

    task automatic random_mix(input int n);
        int k;
        int roll;
        int c;
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 12) free_noise();
            else if (roll < 55 && live_offs.size() > 0) free_live();
            else begin
                c = $urandom_range(99);
                // favor big classes so slabs fill, drain and move between lists
                if (c < 5) c = 8;
                else if (c < 70) c = 5 + (c % 3);
                else c = c % 5;
                alloc_class(c);
            end
        end
    endtask

    // wait for every queued beat and result, then for the pipeline to settle
    task automatic drain();
        while (n_taken != n_pushed || result_q.size() != 0) @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_POOL_BASE) sh_base = val;
        else sh_pages = val[6:0];
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // input beat driver
    always @(negedge clk)
    begin
        logic [64:0] item;
        if (rst_n)
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    item = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item[0];
                    s_tdata  <= item[64:1];
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            beat_taken = 1'b0;
        end
    end

    // result ready, with an optional long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                m_tready <= 1'b0;
                hold_cnt = hold_cnt - 1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // monitor: input acceptance and result check
    always @(posedge clk)
    begin
        alloc_result_t want;
        alloc_result_t got;
        if (rst_n && s_tvalid && s_tready)
        begin
            beat_taken = 1'b1;
            n_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[33:32], m_tdata[37:34]};
            if (result_q.size() == 0)
            begin
                $display("%0t unexpected result beat: actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (got.addr !== want.addr)
                begin
                    $display("%0t result_addr: expected %h actual %h", $time, want.addr, got.addr);
                    errors++;
                end
                if (got.st !== want.st)
                begin
                    $display("%0t status: expected %0d actual %0d", $time, want.st, got.st);
                    errors++;
                end
                if (got.cls !== want.cls)
                begin
                    $display("%0t size_class: expected %0d actual %0d", $time, want.cls, got.cls);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int k;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = 1'b0;
        cfg_data   = '0;
        n_pushed   = 0;
        n_taken    = 0;
        errors     = 0;
        cycles     = 0;
        send_idle  = 0;
        recv_idle  = 0;
        hold_cnt   = 0;
        beat_taken = 1'b0;
        sh_base    = 32'd1048576;
        sh_pages   = 7'd64;
        sh_used    = 0;
        for (k = 0; k < NUM_PAGES; k++)
        begin
            sh_next_pg[k] = NIL;
            sh_prev_pg[k] = NIL;
        end
        for (k = 0; k < NUM_LISTS; k++) sh_heads[k] = NIL;
        for (k = 0; k < NUM_PAGES*256; k++) sh_obj_live[k] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: class edges, large, bad frees, double free, slab reuse
        queue_req(CMD_ALLOC, 0, 0);
        queue_req(CMD_ALLOC, 8, 0);
        queue_req(CMD_ALLOC, 9, 0);
        queue_req(CMD_ALLOC, 2040, 0);
        queue_req(CMD_ALLOC, 2041, 0);
        queue_req(CMD_ALLOC, 32'hFFFFFFFF, 0);
        queue_req(CMD_FREE, 32'hFFFFFFFF, 0);
        queue_req(CMD_FREE, 0, 5);
        queue_req(CMD_FREE, 0, base_al() + 4*4096 + 8);
        queue_req(CMD_FREE, 0, base_al() + 4*4096 + 8);
        queue_req(CMD_FREE, 0, base_al() + 5*4096 + 16);
        queue_req(CMD_FREE, 0, base_al() + 3*4096 + 24 + 4);
        queue_req(CMD_FREE, 0, base_al() + 3*4096 + 24);
        queue_req(CMD_ALLOC, 2000, 0);
        queue_req(CMD_FREE, 0, base_al() + 60*4096 + 24);
        queue_req(CMD_FREE, 0, base_al() + 3*4096 + 8);
        queue_req(CMD_FREE, 0, base_al() + 0*4096 + 24);
        queue_req(CMD_ALLOC, 1, 0);
        queue_req(CMD_ALLOC, 1000, 0);
        queue_req(CMD_ALLOC, 1000, 0);
        queue_req(CMD_ALLOC, 1000, 0);
        queue_req(CMD_ALLOC, 1000, 0);
        queue_req(CMD_FREE, 0, base_al() + 6*4096 + 24);
        live_offs.delete();
        drain();

        // phase: no idling, long receiver hold-off to back up the input
        hold_cnt = 300;
        random_mix(200);
        drain();

        // phase: sender idle, unaligned base, tight page limit
        write_reg(CFG_POOL_BASE, 32'h0000_0ABC);
        write_reg(CFG_POOL_PAGES, 7'd20);
        live_offs.delete();
        freed_offs.delete();
        send_idle = 79;
        random_mix(200);
        drain();

        // phase: receiver stalls, top base with address wrap, page limit above size
        write_reg(CFG_POOL_BASE, 32'hFFFFF000);
        write_reg(CFG_POOL_PAGES, 7'd127);
        live_offs.delete();
        freed_offs.delete();
        send_idle = 0;
        recv_idle = 79;
        random_mix(200);
        drain();

        // phase: both idle, base zero, page limits of one and none, then 64
        write_reg(CFG_POOL_BASE, 32'h0);
        write_reg(CFG_POOL_PAGES, 7'd1);
        live_offs.delete();
        freed_offs.delete();
        send_idle = 26;
        recv_idle = 26;
        random_mix(60);
        drain();
        write_reg(CFG_POOL_PAGES, 7'd0);
        random_mix(40);
        drain();
        write_reg(CFG_POOL_PAGES, 7'd64);
        random_mix(100);
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== size_class_slab_allocator.f =====
src/scsa_pkg.sv
src/scsa_ram.sv
src/scsa_front.sv
src/scsa_fifo.sv
src/scsa_back.sv
src/size_class_slab_allocator.sv
tb/tb_size_class_slab_allocator.sv
